/* rtl/core/glos_pkg.sv */
// Shared types, constants and codes of the grid line-of-sight tracer.
`timescale 1ns / 1ps
`default_nettype none

package glos_pkg;

	// Grid and coordinate geometry.
	localparam int MAX_COLUMNS = 64;
	localparam int MAX_ROWS    = 64;
	localparam int COORD_BITS  = 16;
	localparam int TILE_COUNT  = MAX_COLUMNS * MAX_ROWS;
	localparam int TILE_BITS   = $clog2(TILE_COUNT);

	// Widths of the configuration fields and of derived quantities.
	localparam int SIZE_BITS = 8;
	localparam int MAP_BITS  = 7;
	localparam int DIM_BITS  = 11;
	localparam int CMP_BITS  = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
	localparam int ERR_BITS  = COORD_BITS + 3;

	// Configuration port.
	localparam int ADDR_BITS = 4;
	localparam int DATA_BITS = 32;

	localparam logic [SIZE_BITS-1:0] TILE_WIDTH_RESET  = SIZE_BITS'(16);
	localparam logic [SIZE_BITS-1:0] TILE_HEIGHT_RESET = SIZE_BITS'(16);
	localparam logic [MAP_BITS-1:0]  MAP_COLUMNS_RESET = MAP_BITS'(64);
	localparam logic [MAP_BITS-1:0]  MAP_ROWS_RESET    = MAP_BITS'(64);

	typedef enum logic [1:0] {
		REG_TILE_WIDTH,
		REG_TILE_HEIGHT,
		REG_MAP_COLUMNS,
		REG_MAP_ROWS
	} glos_reg_t;

	typedef enum logic [1:0] {
		CMD_WRITE_WALL,
		CMD_CAST_RAY,
		CMD_READ_TILE,
		CMD_CLEAR_VIS
	} glos_op_t;

	typedef struct packed {
		glos_op_t                      cmd;
		logic [5:0]                    tile_col;
		logic [5:0]                    tile_row;
		logic                          wall;
		logic signed [COORD_BITS-1:0]  start_x;
		logic signed [COORD_BITS-1:0]  start_y;
		logic signed [COORD_BITS-1:0]  end_x;
		logic signed [COORD_BITS-1:0]  end_y;
	} glos_in_t;

	typedef struct packed {
		logic reached;
		logic tile_visible;
		logic tile_wall;
	} glos_out_t;

	typedef struct packed {
		logic [SIZE_BITS-1:0] tile_width;
		logic [SIZE_BITS-1:0] tile_height;
		logic [MAP_BITS-1:0]  map_columns;
		logic [MAP_BITS-1:0]  map_rows;
	} glos_cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_in;
		logic setup1;
		logic setup2;
		logic load_axes;
		logic step;
		logic mark_vis;
		logic rd_wall;
		logic rd_tile;
		logic wr_wall;
		logic clr_vis;
		logic res_we;
		logic res_reached;
		logic out_load;
	} glos_dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		glos_op_t op;
		logic     short_ray;
		logic     div_busy;
		logic     walk_done;
		logic     step_changed;
		logic     in_map;
		logic     hit_wall;
		logic     sweep_last;
	} glos_dp_stat_t;

	typedef enum logic [3:0] {
		ST_RESET_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_WRITE,
		ST_READ,
		ST_CLEAR,
		ST_SETUP1,
		ST_SETUP2,
		ST_DIV,
		ST_SHORT,
		ST_STEP,
		ST_TEST,
		ST_WALL,
		ST_DONE
	} glos_state_t;

endpackage

`default_nettype wire

/* rtl/core/glos_div.sv */
// Serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module glos_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [glos_pkg::COORD_BITS-1:0]    dividend,
	input  wire logic [glos_pkg::SIZE_BITS-1:0]     divisor,
	output logic                                    busy,
	output logic [glos_pkg::COORD_BITS-1:0]         quot,
	output logic [glos_pkg::SIZE_BITS-1:0]          rem
);
	import glos_pkg::*;

	localparam int CNT_BITS = $clog2(COORD_BITS + 1);

	logic [CNT_BITS-1:0]   cnt_q;
	logic [COORD_BITS-1:0] dq_q;
	logic [SIZE_BITS-1:0]  rem_q;
	logic [SIZE_BITS-1:0]  dvs_q;
	logic [SIZE_BITS:0]    trial;
	logic                  fits;

	// The partial remainder stays below the divisor, so one extra bit holds the shift.
	assign trial = {rem_q, dq_q[COORD_BITS-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_BITS'(COORD_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			dq_q <= {dq_q[COORD_BITS-2:0], fits};
			if (fits) begin
				rem_q <= SIZE_BITS'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= SIZE_BITS'(trial);
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = dq_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

/* rtl/core/glos_dp.sv */
// Datapath: tile stores, ray setup, Bresenham stepper with tile tracking, result register.
`timescale 1ns / 1ps
`default_nettype none

module glos_dp (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire glos_pkg::glos_dp_cmd_t  cmd,
	input  wire glos_pkg::glos_cfg_t     cfg,
	input  wire glos_pkg::glos_in_t      in_data,
	output glos_pkg::glos_dp_stat_t      stat,
	output glos_pkg::glos_out_t          rsp_data
);
	import glos_pkg::*;

	// Position along one axis as sign, magnitude, and the magnitude split by the tile size.
	typedef struct packed {
		logic                  neg;
		logic [COORD_BITS-1:0] mag;
		logic [COORD_BITS-1:0] q;
		logic [SIZE_BITS-1:0]  rem;
	} axis_t;

	function automatic axis_t axis_step(axis_t a, logic dir_neg, logic [SIZE_BITS-1:0] w);
		axis_t r;
		logic  grow;
		r    = a;
		grow = (a.mag == '0) || (dir_neg == a.neg);
		if (a.mag == '0) begin
			r.neg = dir_neg;
		end
		if (grow) begin
			r.mag = a.mag + COORD_BITS'(1);
			if (({1'b0, a.rem} + (SIZE_BITS + 1)'(1)) == {1'b0, w}) begin
				r.q   = a.q + COORD_BITS'(1);
				r.rem = '0;
			end else begin
				r.rem = a.rem + SIZE_BITS'(1);
			end
		end else begin
			r.mag = a.mag - COORD_BITS'(1);
			if (a.rem == '0) begin
				r.q   = a.q - COORD_BITS'(1);
				r.rem = w - SIZE_BITS'(1);
			end else begin
				r.rem = a.rem - SIZE_BITS'(1);
			end
		end
		return r;
	endfunction

	glos_in_t in_q;
	glos_out_t rsp_q;
	logic reached_q;

	logic [SIZE_BITS-1:0] w_eff;
	logic [SIZE_BITS-1:0] h_eff;
	logic [DIM_BITS-1:0]  cols_eff;
	logic [DIM_BITS-1:0]  rows_eff;

	// Ray setup.
	logic signed [COORD_BITS:0] dx_pos, dx_neg, dy_pos, dy_neg;
	logic [COORD_BITS-1:0] adx_q, ady_q, magx_q, magy_q;
	logic [COORD_BITS-1:0] magx_in, magy_in;
	logic xs_neg_q, ys_neg_q, x_major_q, short_q;
	logic signed [ERR_BITS-1:0] adx_e, ady_e;
	logic signed [ERR_BITS-1:0] err_q, inca_q, incb_q;
	logic [COORD_BITS-1:0] left_q;

	// Walk state.
	axis_t ax_q, ay_q, ax_n, ay_n;
	logic side, move_x, move_y;
	logic col_ok, row_ok;

	// Dividers for the start tile.
	logic div_busy_x, div_busy_y;
	logic [COORD_BITS-1:0] quot_x, quot_y;
	logic [SIZE_BITS-1:0]  rem_x, rem_y;

	// Stores.
	logic wall_mem [TILE_COUNT];
	logic vis_mem  [TILE_COUNT];
	logic rd_wall_q, rd_vis_q;
	logic [TILE_BITS-1:0] cmd_idx, walk_idx, wall_addr, vis_addr, sweep_q;
	logic tile_ok;

	assign w_eff    = (cfg.tile_width  == '0) ? SIZE_BITS'(1) : cfg.tile_width;
	assign h_eff    = (cfg.tile_height == '0) ? SIZE_BITS'(1) : cfg.tile_height;
	assign cols_eff = (DIM_BITS'(cfg.map_columns) > DIM_BITS'(MAX_COLUMNS)) ?
		DIM_BITS'(MAX_COLUMNS) : DIM_BITS'(cfg.map_columns);
	assign rows_eff = (DIM_BITS'(cfg.map_rows) > DIM_BITS'(MAX_ROWS)) ?
		DIM_BITS'(MAX_ROWS) : DIM_BITS'(cfg.map_rows);

	// Differences are formed both ways in parallel and picked by sign.
	assign dx_pos = (COORD_BITS + 1)'(in_q.end_x) - (COORD_BITS + 1)'(in_q.start_x);
	assign dx_neg = (COORD_BITS + 1)'(in_q.start_x) - (COORD_BITS + 1)'(in_q.end_x);
	assign dy_pos = (COORD_BITS + 1)'(in_q.end_y) - (COORD_BITS + 1)'(in_q.start_y);
	assign dy_neg = (COORD_BITS + 1)'(in_q.start_y) - (COORD_BITS + 1)'(in_q.end_y);
	assign magx_in = in_q.start_x[COORD_BITS-1] ?
		COORD_BITS'(-in_q.start_x) : COORD_BITS'(in_q.start_x);
	assign magy_in = in_q.start_y[COORD_BITS-1] ?
		COORD_BITS'(-in_q.start_y) : COORD_BITS'(in_q.start_y);

	assign adx_e = $signed(ERR_BITS'(adx_q));
	assign ady_e = $signed(ERR_BITS'(ady_q));

	glos_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.setup1),
		.dividend (magx_in),
		.divisor  (w_eff),
		.busy     (div_busy_x),
		.quot     (quot_x),
		.rem      (rem_x)
	);

	glos_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.setup1),
		.dividend (magy_in),
		.divisor  (h_eff),
		.busy     (div_busy_y),
		.quot     (quot_y),
		.rem      (rem_y)
	);

	// One Bresenham step.
	assign side   = (err_q > $signed(ERR_BITS'(0)));
	assign move_x = x_major_q | side;
	assign move_y = ~x_major_q | side;
	assign ax_n   = move_x ? axis_step(ax_q, xs_neg_q, w_eff) : ax_q;
	assign ay_n   = move_y ? axis_step(ay_q, ys_neg_q, h_eff) : ay_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			in_q <= in_data;
		end
		if (cmd.setup1) begin
			adx_q    <= dx_pos[COORD_BITS] ? COORD_BITS'(dx_neg) : COORD_BITS'(dx_pos);
			ady_q    <= dy_pos[COORD_BITS] ? COORD_BITS'(dy_neg) : COORD_BITS'(dy_pos);
			xs_neg_q <= dx_pos[COORD_BITS];
			ys_neg_q <= dy_pos[COORD_BITS];
			magx_q   <= magx_in;
			magy_q   <= magy_in;
		end
		if (cmd.setup2) begin
			x_major_q <= (adx_q >= ady_q);
			short_q   <= ({1'b0, adx_q} <= (COORD_BITS + 1)'(w_eff)) &&
				({1'b0, ady_q} <= (COORD_BITS + 1)'(h_eff));
			if (adx_q >= ady_q) begin
				left_q <= adx_q;
				err_q  <= ady_e + ady_e - adx_e;
				inca_q <= ady_e + ady_e;
				incb_q <= (ady_e - adx_e) + (ady_e - adx_e);
			end else begin
				left_q <= ady_q;
				err_q  <= adx_e + adx_e - ady_e;
				inca_q <= adx_e + adx_e;
				incb_q <= (adx_e - ady_e) + (adx_e - ady_e);
			end
		end
		if (cmd.load_axes) begin
			ax_q <= '{neg: in_q.start_x[COORD_BITS-1], mag: magx_q, q: quot_x, rem: rem_x};
			ay_q <= '{neg: in_q.start_y[COORD_BITS-1], mag: magy_q, q: quot_y, rem: rem_y};
		end else if (cmd.step) begin
			ax_q   <= ax_n;
			ay_q   <= ay_n;
			err_q  <= err_q + (side ? incb_q : inca_q);
			left_q <= left_q - COORD_BITS'(1);
		end
	end

	// Tile of the current walk position; a negative tile is outside unless it is tile zero.
	assign col_ok = (!ax_q.neg || ax_q.q == '0) && (CMP_BITS'(ax_q.q) < CMP_BITS'(cols_eff));
	assign row_ok = (!ay_q.neg || ay_q.q == '0) && (CMP_BITS'(ay_q.q) < CMP_BITS'(rows_eff));
	assign walk_idx = TILE_BITS'(ay_q.q) * TILE_BITS'(MAX_COLUMNS) + TILE_BITS'(ax_q.q);

	assign tile_ok = (DIM_BITS'(in_q.tile_col) < DIM_BITS'(MAX_COLUMNS)) &&
		(DIM_BITS'(in_q.tile_row) < DIM_BITS'(MAX_ROWS));
	assign cmd_idx = TILE_BITS'(in_q.tile_row) * TILE_BITS'(MAX_COLUMNS) +
		TILE_BITS'(in_q.tile_col);

	assign wall_addr = cmd.rd_wall ? walk_idx : cmd_idx;
	assign vis_addr  = cmd.clr_vis ? sweep_q : (cmd.mark_vis ? walk_idx : cmd_idx);

	always_ff @(posedge clk) begin
		if (cmd.wr_wall && tile_ok) begin
			wall_mem[wall_addr] <= in_q.wall;
		end
		if (cmd.rd_wall || cmd.rd_tile) begin
			rd_wall_q <= wall_mem[wall_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_vis || cmd.mark_vis) begin
			vis_mem[vis_addr] <= cmd.mark_vis;
		end
		if (cmd.rd_tile) begin
			rd_vis_q <= vis_mem[vis_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.clr_vis) begin
			if (sweep_q == TILE_BITS'(TILE_COUNT - 1)) begin
				sweep_q <= '0;
			end else begin
				sweep_q <= sweep_q + TILE_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			reached_q <= 1'b0;
		end else if (cmd.res_we) begin
			reached_q <= cmd.res_reached;
		end
		if (cmd.out_load) begin
			rsp_q.reached      <= (in_q.cmd == CMD_CAST_RAY) & reached_q;
			rsp_q.tile_visible <= (in_q.cmd == CMD_READ_TILE) & tile_ok & rd_vis_q;
			rsp_q.tile_wall    <= (in_q.cmd == CMD_READ_TILE) & tile_ok & rd_wall_q;
		end
	end

	assign rsp_data = rsp_q;

	assign stat.op           = in_q.cmd;
	assign stat.short_ray    = short_q;
	assign stat.div_busy     = div_busy_x | div_busy_y;
	assign stat.walk_done    = (left_q == '0);
	assign stat.step_changed = (ax_n.q != ax_q.q) || (ay_n.q != ay_q.q);
	assign stat.in_map       = col_ok & row_ok;
	assign stat.hit_wall     = rd_wall_q;
	assign stat.sweep_last   = (sweep_q == TILE_BITS'(TILE_COUNT - 1));

endmodule

`default_nettype wire

/* rtl/core/glos_ctrl.sv */
// Controller: command sequencing, clearing sweeps, ray walk control and response valid.
`timescale 1ns / 1ps
`default_nettype none

module glos_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cmd_valid,
	output logic                         cmd_stall,
	output logic                         rsp_valid,
	input  wire logic                    rsp_stall,
	input  wire glos_pkg::glos_dp_stat_t stat,
	output glos_pkg::glos_dp_cmd_t       cmd
);
	import glos_pkg::*;

	glos_state_t state_q, state_n;
	logic rsp_valid_q;
	logic rsp_free;

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RESET_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			ST_RESET_CLEAR: begin
				cmd.clr_vis = 1'b1;
				if (stat.sweep_last) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd.latch_in = 1'b1;
					state_n      = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (stat.op)
					CMD_WRITE_WALL: state_n = ST_WRITE;
					CMD_CAST_RAY:   state_n = ST_SETUP1;
					CMD_READ_TILE:  state_n = ST_READ;
					CMD_CLEAR_VIS:  state_n = ST_CLEAR;
					default:        state_n = ST_DONE;
				endcase
			end
			ST_WRITE: begin
				cmd.wr_wall = 1'b1;
				state_n     = ST_DONE;
			end
			ST_READ: begin
				cmd.rd_tile = 1'b1;
				state_n     = ST_DONE;
			end
			ST_CLEAR: begin
				cmd.clr_vis = 1'b1;
				if (stat.sweep_last) begin
					state_n = ST_DONE;
				end
			end
			ST_SETUP1: begin
				cmd.setup1 = 1'b1;
				state_n    = ST_SETUP2;
			end
			ST_SETUP2: begin
				cmd.setup2 = 1'b1;
				state_n    = ST_DIV;
			end
			ST_DIV: begin
				if (!stat.div_busy) begin
					cmd.load_axes = 1'b1;
					state_n       = stat.short_ray ? ST_SHORT : ST_STEP;
				end
			end
			ST_SHORT: begin
				cmd.mark_vis    = stat.in_map;
				cmd.res_we      = 1'b1;
				cmd.res_reached = 1'b1;
				state_n         = ST_DONE;
			end
			ST_STEP: begin
				if (stat.walk_done) begin
					cmd.res_we      = 1'b1;
					cmd.res_reached = 1'b1;
					state_n         = ST_DONE;
				end else begin
					cmd.step = 1'b1;
					if (stat.step_changed) begin
						state_n = ST_TEST;
					end
				end
			end
			ST_TEST: begin
				if (!stat.in_map) begin
					cmd.res_we      = 1'b1;
					cmd.res_reached = 1'b1;
					state_n         = ST_DONE;
				end else begin
					cmd.mark_vis = 1'b1;
					cmd.rd_wall  = 1'b1;
					state_n      = ST_WALL;
				end
			end
			ST_WALL: begin
				if (stat.hit_wall) begin
					cmd.res_we      = 1'b1;
					cmd.res_reached = 1'b0;
					state_n         = ST_DONE;
				end else begin
					state_n = ST_STEP;
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

/* rtl/core/grid_line_of_sight_tracer.sv */
// Top level of the grid line-of-sight tracer: configuration registers, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// The tracer keeps a wall bit and a visibility bit for every tile of the grid. Each beat on the
// command channel (cmd_valid, cmd_stall, cmd_data) carries one command: write a wall tile, cast
// a ray between two pixel points, read a tile, or clear all visibility bits. Every command gives
// exactly one beat on the response channel (rsp_valid, rsp_stall, rsp_data).
// A write or read passes through dispatch, the store access and the done state before its
// response is loaded. A clear sweeps the visibility store one tile per cycle. A ray first runs
// its setup, most of it in the serial dividers that find the start tile (one quotient bit per
// cycle); then the Bresenham stepper walks one pixel per cycle while it stays inside a tile,
// and on every tile boundary it crosses it stops for a test state (map test, visibility mark
// and wall lookup) and then a wall state that checks the wall bit.
// Commands are handled one at a time; cmd_stall is high while a command is in progress.
// A finished response sits in an output register, and the next command is taken while it waits.
// If the receiver holds rsp_stall, the response beat holds and the following command stops just
// before its own response until the register frees up.
// After reset the block clears the visibility store, with cmd_stall high. The configuration
// registers (tile size and map size) sit on the APB port at byte addresses 0, 4, 8 and 12 and
// are to be written only while no command is in progress; the block leaves this to the user.

module grid_line_of_sight_tracer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cmd_valid,
	output logic                                   cmd_stall,
	input  wire glos_pkg::glos_in_t                cmd_data,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output glos_pkg::glos_out_t                    rsp_data,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [glos_pkg::ADDR_BITS-1:0]    paddr,
	input  wire logic [glos_pkg::DATA_BITS-1:0]    pwdata,
	output logic [glos_pkg::DATA_BITS-1:0]         prdata,
	output logic                                   pready
);
	import glos_pkg::*;

	glos_cfg_t     cfg_q;
	glos_dp_cmd_t  dp_cmd;
	glos_dp_stat_t dp_stat;
	glos_reg_t     reg_sel;
	logic          cfg_write;

	// Register index is the word address; the port never waits.
	assign reg_sel   = glos_reg_t'(paddr[3:2]);
	assign cfg_write = psel & penable & pwrite;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tile_width  <= TILE_WIDTH_RESET;
			cfg_q.tile_height <= TILE_HEIGHT_RESET;
			cfg_q.map_columns <= MAP_COLUMNS_RESET;
			cfg_q.map_rows    <= MAP_ROWS_RESET;
		end else if (cfg_write) begin
			case (reg_sel)
				REG_TILE_WIDTH:  cfg_q.tile_width  <= pwdata[SIZE_BITS-1:0];
				REG_TILE_HEIGHT: cfg_q.tile_height <= pwdata[SIZE_BITS-1:0];
				REG_MAP_COLUMNS: cfg_q.map_columns <= pwdata[MAP_BITS-1:0];
				REG_MAP_ROWS:    cfg_q.map_rows    <= pwdata[MAP_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_TILE_WIDTH:  prdata = DATA_BITS'(cfg_q.tile_width);
			REG_TILE_HEIGHT: prdata = DATA_BITS'(cfg_q.tile_height);
			REG_MAP_COLUMNS: prdata = DATA_BITS'(cfg_q.map_columns);
			REG_MAP_ROWS:    prdata = DATA_BITS'(cfg_q.map_rows);
			default:         prdata = '0;
		endcase
	end

	// The controller sequences every command; the datapath holds the stores and the walker.
	glos_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	glos_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (dp_cmd),
		.cfg      (cfg_q),
		.in_data  (cmd_data),
		.stat     (dp_stat),
		.rsp_data (rsp_data)
	);

endmodule

`default_nettype wire
